// ===== rtl/core/nmda_ccur_pkg.sv =====
// Package for the NMDA conductance current block: widths, fixed-point constants,
// register indexes and the series used to build the 2^x table.
// Used by the divider and the top level of the block; depends on nothing else.
package nmda_ccur_pkg;

    localparam int DEN_W = 40;
    localparam int NUM_W = 56;
    localparam int QUO_W = 36;

    localparam logic [63:0] LN2_Q30   = 64'd744261118;
    localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;

    localparam logic [1:0] REG_NMDA_MODE = 2'd0;
    localparam logic [1:0] REG_REVERSAL  = 2'd1;
    localparam logic [1:0] REG_GAIN      = 2'd2;
    localparam logic [1:0] REG_SLOPE     = 2'd3;

    function automatic logic [63:0] exp_series_q30(input logic [63:0] x);
        logic [63:0] sum;
        logic [63:0] term;
        sum  = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int k = 1; k < 40; k++) begin
            term = ((term * x) >> 30) / 64'(k);
            sum  = sum + term;
        end
        return sum;
    endfunction

endpackage

// ===== rtl/core/nmda_ccur_div.sv =====
// Pipelined restoring divider with one quotient bit per stage.
// Depends on nmda_ccur_pkg for operand and quotient widths.
module nmda_ccur_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [nmda_ccur_pkg::NUM_W-1:0]   in_num,
    input  logic [nmda_ccur_pkg::DEN_W-1:0]   in_den,
    input  logic                              in_neg,
    output logic                              out_valid,
    output logic [nmda_ccur_pkg::QUO_W-1:0]   out_quot,
    output logic                              out_neg
);
    localparam int DW = nmda_ccur_pkg::DEN_W;
    localparam int QW = nmda_ccur_pkg::QUO_W;
    localparam int NW = nmda_ccur_pkg::NUM_W;

    logic [DW-1:0] rem_reg [0:QW-1];
    logic [DW-1:0] den_reg [0:QW-1];
    logic [QW-1:0] low_reg [0:QW-1];
    logic [QW-1:0] quo_reg [0:QW-1];
    logic [QW-1:0] neg_reg;
    logic [QW-1:0] vld_reg;

    genvar gk;
    for (gk = 0; gk < QW; gk++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] quo_in;
        logic          neg_in;
        logic          vld_in;
        logic [DW:0]   shifted;
        logic          ge;
        logic [DW:0]   diff;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] low_next;
        logic [QW-1:0] quo_next;

        if (gk == 0) begin : g_first
            assign rem_in = DW'(in_num[NW-1:QW]);
            assign den_in = in_den;
            assign low_in = in_num[QW-1:0];
            assign quo_in = '0;
            assign neg_in = in_neg;
            assign vld_in = in_valid;
        end else begin : g_next
            assign rem_in = rem_reg[gk-1];
            assign den_in = den_reg[gk-1];
            assign low_in = low_reg[gk-1];
            assign quo_in = quo_reg[gk-1];
            assign neg_in = neg_reg[gk-1];
            assign vld_in = vld_reg[gk-1];
        end

        always_comb begin
            shifted  = {rem_in, low_in[QW-1]};
            ge       = shifted >= {1'b0, den_in};
            diff     = shifted - {1'b0, den_in};
            rem_next = ge ? diff[DW-1:0] : shifted[DW-1:0];
            low_next = {low_in[QW-2:0], 1'b0};
            quo_next = {quo_in[QW-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[gk] <= 1'b0;
            end else if (en) begin
                vld_reg[gk] <= vld_in;
            end
            if (en) begin
                rem_reg[gk] <= rem_next;
                den_reg[gk] <= den_in;
                low_reg[gk] <= low_next;
                quo_reg[gk] <= quo_next;
                neg_reg[gk] <= neg_in;
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign out_quot  = quo_reg[QW-1];
    assign out_neg   = neg_reg[QW-1];

endmodule

// ===== rtl/core/nmda_conductance_current.sv =====
// Top level of the NMDA conductance current block: front pipeline, 2^x table and divider.
// Depends on nmda_ccur_pkg and nmda_ccur_div.
//
// The block takes one conductance and voltage word per cycle when the output is not stalled
// and returns one current word for each, in order: eight front stages compute the product,
// the exponent and the denominator, then a 36-stage divider produces one quotient bit per
// stage, and an output register holds the result.
// A stall on the result side freezes the whole pipeline, so the input ready follows
// the output ready in the same cycle.
module nmda_conductance_current #(
    parameter int EXP_TABLE_DEPTH = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [23:0] s_conductance,
    input  logic signed [23:0] s_membrane_voltage,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [47:0] m_current,
    output logic               m_saturated
);
    localparam int TAB_AW = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int FD_W   = 20 + TAB_AW;
    localparam int DW     = nmda_ccur_pkg::DEN_W;
    localparam int QW     = nmda_ccur_pkg::QUO_W;
    localparam int NW     = nmda_ccur_pkg::NUM_W;
    localparam logic signed [48:0] A_CLAMP = 49'sh10_0000_0000;
    localparam logic [DW-1:0] DEN_ONE = DW'(1) << 20;
    localparam logic [47:0] OUT_MAX = 48'h7FFF_FFFF_FFFF;

    logic               nmda_mode_reg;
    logic signed [23:0] reversal_reg;
    logic [23:0]        gain_reg;
    logic [23:0]        slope_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nmda_mode_reg <= 1'b0;
            reversal_reg  <= '0;
            gain_reg      <= '0;
            slope_reg     <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                nmda_ccur_pkg::REG_NMDA_MODE: nmda_mode_reg <= cfg_wdata[0];
                nmda_ccur_pkg::REG_REVERSAL:  reversal_reg  <= cfg_wdata;
                nmda_ccur_pkg::REG_GAIN:      gain_reg      <= cfg_wdata;
                nmda_ccur_pkg::REG_SLOPE:     slope_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [31:0] exp_tab [0:EXP_TABLE_DEPTH];
    genvar gi;
    for (gi = 0; gi <= EXP_TABLE_DEPTH; gi++) begin : g_tab
        localparam logic [63:0] TAB_X =
            (64'(gi) * nmda_ccur_pkg::LN2_Q30) / 64'(EXP_TABLE_DEPTH);
        assign exp_tab[gi] = 32'(nmda_ccur_pkg::exp_series_q30(TAB_X));
    end

    logic en;
    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    logic [8:1] vld_reg;

    // Stage 1
    logic [22:0]        gc_reg;
    logic signed [24:0] diff_reg;
    logic signed [48:0] amul_reg;
    // Stage 2
    logic signed [47:0] prod_reg;
    logic signed [25:0] a20_reg;
    // Stage 3
    logic               neg3_reg;
    logic [46:0]        mag3_reg;
    logic signed [57:0] tmul_reg;
    // Stage 4
    logic               neg4_reg;
    logic [46:0]        mag4_reg;
    logic [31:0]        lo_reg;
    logic [31:0]        hi_reg;
    logic [19:0]        r_reg;
    logic signed [5:0]  n4_reg;
    // Stage 5
    logic               neg5_reg;
    logic [46:0]        mag5_reg;
    logic [31:0]        m_reg;
    logic signed [5:0]  n5_reg;
    // Stage 6
    logic               neg6_reg;
    logic [46:0]        mag6_reg;
    logic [55:0]        pk_reg;
    logic signed [5:0]  n6_reg;
    // Stage 7
    logic               neg7_reg;
    logic [46:0]        mag7_reg;
    logic [DW-1:0]      den7_reg;
    // Stage 8
    logic               neg8_reg;
    logic [NW-1:0]      num8_reg;
    logic [DW-1:0]      den8_reg;

    logic [22:0]        gc_next;
    logic signed [24:0] diff_next;
    logic signed [48:0] amul_next;
    logic signed [48:0] prod49;
    logic signed [48:0] aneg;
    logic signed [48:0] aclp;
    logic signed [25:0] a20_next;
    logic [47:0]        negprod;
    logic signed [57:0] tmul_next;
    logic signed [25:0] t_val;
    logic [FD_W-1:0]    fd;
    logic [TAB_AW-1:0]  idx;
    logic [TAB_AW-1:0]  idx_p1;
    logic [19:0]        r_next;
    logic [31:0]        dlt;
    logic [51:0]        interp;
    logic [6:0]         s_amt;
    logic [55:0]        pk_sh;
    logic [DW-1:0]      den7_next;
    logic [NW-1:0]      num8_next;

    always_comb begin
        gc_next   = s_conductance[23] ? 23'd0 : s_conductance[22:0];
        diff_next = {reversal_reg[23], reversal_reg}
                  - {s_membrane_voltage[23], s_membrane_voltage};
        amul_next = $signed({1'b0, slope_reg}) * s_membrane_voltage;

        prod49 = $signed({1'b0, gc_reg}) * diff_reg;
        aneg   = -amul_reg;
        if (aneg > A_CLAMP) begin
            aclp = A_CLAMP;
        end else if (aneg < -A_CLAMP) begin
            aclp = -A_CLAMP;
        end else begin
            aclp = aneg;
        end
        a20_next = aclp[37:12];

        negprod   = -prod_reg;
        tmul_next = a20_reg * $signed({1'b0, nmda_ccur_pkg::LOG2E_Q30});

        t_val = tmul_reg[55:30];
        fd    = FD_W'(t_val[19:0]) * FD_W'(EXP_TABLE_DEPTH);
        if (fd[FD_W-1:20] >= TAB_AW'(EXP_TABLE_DEPTH)) begin
            idx    = TAB_AW'(EXP_TABLE_DEPTH - 1);
            r_next = 20'hFFFFF;
        end else begin
            idx    = fd[FD_W-1:20];
            r_next = fd[19:0];
        end
        idx_p1 = idx + TAB_AW'(1);

        dlt    = (hi_reg >= lo_reg) ? hi_reg - lo_reg : 32'd0;
        interp = 52'(dlt) * 52'(r_reg);

        s_amt = 7'd40 - 7'({n6_reg[5], n6_reg});
        pk_sh = pk_reg >> s_amt;
        den7_next = nmda_mode_reg ? DEN_ONE + pk_sh[DW-1:0] : DEN_ONE;

        num8_next = NW'({mag7_reg, 8'd0}) + NW'(den7_reg >> 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[7:1], s_valid};
        end
        if (en) begin
            gc_reg   <= gc_next;
            diff_reg <= diff_next;
            amul_reg <= amul_next;

            prod_reg <= prod49[47:0];
            a20_reg  <= a20_next;

            neg3_reg <= prod_reg[47];
            mag3_reg <= prod_reg[47] ? negprod[46:0] : prod_reg[46:0];
            tmul_reg <= tmul_next;

            neg4_reg <= neg3_reg;
            mag4_reg <= mag3_reg;
            lo_reg   <= exp_tab[idx];
            hi_reg   <= exp_tab[idx_p1];
            r_reg    <= r_next;
            n4_reg   <= t_val[25:20];

            neg5_reg <= neg4_reg;
            mag5_reg <= mag4_reg;
            m_reg    <= lo_reg + interp[51:20];
            n5_reg   <= n4_reg;

            neg6_reg <= neg5_reg;
            mag6_reg <= mag5_reg;
            pk_reg   <= 56'(gain_reg) * 56'(m_reg);
            n6_reg   <= n5_reg;

            neg7_reg <= neg6_reg;
            mag7_reg <= mag6_reg;
            den7_reg <= den7_next;

            neg8_reg <= neg7_reg;
            num8_reg <= num8_next;
            den8_reg <= den7_reg;
        end
    end

    logic          div_valid;
    logic [QW-1:0] div_quot;
    logic          div_neg;

    nmda_ccur_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vld_reg[8]),
        .in_num    (num8_reg),
        .in_den    (den8_reg),
        .in_neg    (neg8_reg),
        .out_valid (div_valid),
        .out_quot  (div_quot),
        .out_neg   (div_neg)
    );

    logic [47:0]        q48;
    logic signed [47:0] cur_next;
    logic               sat_next;
    logic signed [47:0] m_current_reg;
    logic               m_saturated_reg;

    always_comb begin
        q48 = 48'(div_quot);
        if (!div_neg && q48 > OUT_MAX) begin
            cur_next = $signed(OUT_MAX);
            sat_next = 1'b1;
        end else if (div_neg && q48 > OUT_MAX + 48'd1) begin
            cur_next = $signed(~OUT_MAX);
            sat_next = 1'b1;
        end else begin
            cur_next = div_neg ? $signed(-q48) : $signed(q48);
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= div_valid;
        end
        if (en) begin
            m_current_reg   <= cur_next;
            m_saturated_reg <= sat_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_current   = m_current_reg;
    assign m_saturated = m_saturated_reg;

endmodule

// ===== rtl/core/nmda_ccur_chk.sv =====
// Port-level checker for the NMDA conductance current block, bound to the top level.
// Depends only on the top level's ports.
module nmda_ccur_chk (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [47:0] m_current,
    input logic               m_saturated
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("Result word valid right after reset.");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_current) && $stable(m_saturated))
        else $error("Stalled result word changed.");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("Input word taken while the pipeline is stalled.");

    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |->
            (m_current == 48'sh7FFF_FFFF_FFFF) || (m_current == -48'sh8000_0000_0000))
        else $error("Saturated flag without a clipped current.");

endmodule

bind nmda_conductance_current nmda_ccur_chk u_chk (.*);
